// ----- design/assert_macros.svh -----
// assertion helpers shared by the design files
// each macro samples on clk and is disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define RRCT_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed")
`define RRCT_NEVER(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen")
`else
`define RRCT_ASSERT(lbl, prop)
`define RRCT_NEVER(lbl, expr)
`endif

`endif

// ----- design/rrct_pkg.sv -----
// ----------------------------------------------------------------------------
// rrct_pkg
// shared types and constants of the ring reserve/commit tracker
// ----------------------------------------------------------------------------
package rrct_pkg;

    localparam int CMD_W  = 2;
    localparam int SIZE_W = 17;
    localparam int TK_W   = 5;
    localparam int POS_W  = 32;
    localparam int ST_W   = 3;
    localparam int OFF_W  = 16;
    localparam int RB_W   = 17;

    typedef enum logic [CMD_W-1:0] {
        CMD_RESERVE = 2'd0,
        CMD_COMMIT  = 2'd1,
        CMD_READ    = 2'd2,
        CMD_NONE    = 2'd3
    } cmd_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK      = 3'd0,
        ST_FULL    = 3'd1,
        ST_BADSIZE = 3'd2,
        ST_EMPTY   = 3'd3,
        ST_OVERRUN = 3'd4
    } status_t;

    localparam logic [2:0] ADDR_RING_BYTES = 3'd0;

endpackage

// ----- design/rrct_if.sv -----
// ----------------------------------------------------------------------------
// rrct_req_if / rrct_rsp_if
// valid/ready channels for requests and results
// ----------------------------------------------------------------------------
interface rrct_req_if;
    import rrct_pkg::*;

    logic                valid;
    logic                ready;
    logic [CMD_W-1:0]    cmd;
    logic [SIZE_W-1:0]   size;
    logic [TK_W-1:0]     ticket;
    logic [POS_W-1:0]    read_pos;

    modport source (output valid, cmd, size, ticket, read_pos, input ready);
    modport sink   (input valid, cmd, size, ticket, read_pos, output ready);
endinterface

interface rrct_rsp_if;
    import rrct_pkg::*;

    logic                valid;
    logic                ready;
    logic [ST_W-1:0]     status;
    logic [OFF_W-1:0]    offset;
    logic [SIZE_W-1:0]   length;
    logic [TK_W-1:0]     granted_ticket;
    logic [POS_W-1:0]    new_read_pos;

    modport source (output valid, status, offset, length, granted_ticket, new_read_pos,
                    input ready);
    modport sink   (input valid, status, offset, length, granted_ticket, new_read_pos,
                    output ready);
endinterface

// ----- design/rrct_ram.sv -----
// ----------------------------------------------------------------------------
// rrct_ram
// simple dual port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module rrct_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ----- design/rrct_mod.sv -----
// ----------------------------------------------------------------------------
// rrct_mod
// bit-serial restoring remainder: 32-bit position modulo ring size
// ----------------------------------------------------------------------------
module rrct_mod (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [rrct_pkg::POS_W-1:0]        dividend,
    input  logic [rrct_pkg::RB_W-1:0]         divisor,
    output logic                              done,
    output logic [rrct_pkg::RB_W-1:0]         rem
);
    import rrct_pkg::*;
    `include "assert_macros.svh"

    logic [POS_W-1:0]          quo_reg;
    logic [RB_W-1:0]           rem_reg;
    logic [RB_W-1:0]           div_reg;
    logic [$clog2(POS_W)-1:0]  cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;
    logic [RB_W:0]             shifted;
    logic [RB_W:0]             trial;
    logic                      take;

    // one remainder bit per cycle
    assign shifted = {rem_reg, quo_reg[POS_W-1]};
    assign trial   = shifted - {1'b0, div_reg};
    assign take    = shifted >= {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == ($clog2(POS_W))'(POS_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // operand and remainder datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[POS_W-2:0], 1'b0};
            rem_reg <= take ? trial[RB_W-1:0] : shifted[RB_W-1:0];
        end
    end

    assign done = done_reg;
    assign rem  = rem_reg;

    `RRCT_ASSERT(a_done_after_busy, done_reg |-> $past(busy_reg));
    `RRCT_NEVER(a_no_restart_busy, start && busy_reg);
    `RRCT_ASSERT(a_rem_below_div, done_reg |-> (rem_reg < div_reg));
endmodule

// ----- design/ring_reserve_commit_tracker_core.sv -----
// ----------------------------------------------------------------------------
// ring_reserve_commit_tracker_core
// reserve/commit/read tracker for a byte ring with one shared modulo unit
// ----------------------------------------------------------------------------
// One request is handled at a time; req.ready is low from acceptance until
// the result has been taken from the output register. Every ring offset comes
// from one bit-serial modulo unit. A reserve uses it once (not when refused),
// a read twice (not when nothing is readable at once, once on overrun), and a
// commit once for each done ticket that the safe position moves over. The user
// must write ring_bytes through the APB port only while the block is idle; the
// block itself does not enforce it.
module ring_reserve_commit_tracker_core #(
    parameter int MAX_TICKETS    = 32,
    parameter int MAX_RING_BYTES = 65536
) (
    input  logic         clk,
    input  logic         rst_n,
    rrct_req_if.sink     req,
    rrct_rsp_if.source   rsp,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import rrct_pkg::*;
    `include "assert_macros.svh"

    localparam int IW = $clog2(MAX_TICKETS);
    localparam int TW = $clog2(MAX_TICKETS + 1);
    localparam int CW = (TW > TK_W) ? TW : TK_W;
    localparam int RB_MAXV  = (1 << RB_W) - 1;
    localparam int RB_CLAMP = (MAX_RING_BYTES > RB_MAXV) ? RB_MAXV : MAX_RING_BYTES;
    localparam int RB_RESET = (MAX_RING_BYTES > 65536) ? 65536 : MAX_RING_BYTES;

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_RES_MOD = 8'b0000_0010,
        S_CM_WALK = 8'b0000_0100,
        S_CM_MOD  = 8'b0000_1000,
        S_RD_MOD  = 8'b0001_0000,
        S_RD_ADJ  = 8'b0010_0000,
        S_RD_CHK  = 8'b0100_0000,
        S_RD_WMOD = 8'b1000_0000
    } state_t;

    state_t             state_reg;
    logic [RB_W-1:0]    rb_reg;
    logic [POS_W-1:0]   alloc_reg;
    logic [POS_W-1:0]   safe_reg;
    logic [RB_W-1:0]    gap_reg;
    logic [TW-1:0]      head_reg;
    logic [TW-1:0]      tail_reg;
    logic               done_reg [MAX_TICKETS];
    logic [SIZE_W-1:0]  size_reg;
    logic [POS_W-1:0]   rp_reg;
    logic [RB_W-1:0]    ri_reg;
    logic               out_valid_reg;
    logic [ST_W-1:0]    st_reg;
    logic [OFF_W-1:0]   off_reg;
    logic [SIZE_W-1:0]  len_reg;
    logic [TK_W-1:0]    gt_reg;
    logic [POS_W-1:0]   nrp_reg;

    logic               accept;
    logic               cfg_wr;
    logic [RB_W-1:0]    cfg_val;
    logic               mod_start;
    logic [POS_W-1:0]   mod_arg;
    logic               mod_done;
    logic [RB_W-1:0]    mod_rem;
    logic               ram_we;
    logic               ram_re;
    logic [SIZE_W-1:0]  ram_rdata;
    logic [CW-1:0]      tk_ext;
    logic               tk_live;
    logic               walk_go;
    logic               fits;
    logic [RB_W:0]      step;
    logic [SIZE_W-1:0]  walk_size;
    logic [POS_W-1:0]   rd_diff;
    logic [RB_W-1:0]    limit;

    assign accept = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE) && !out_valid_reg;

    // apb register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == ADDR_RING_BYTES[2]);
    assign prdata = (paddr[2] == ADDR_RING_BYTES[2]) ? {{(32-RB_W){1'b0}}, rb_reg} : '0;

    always_comb
    begin
        cfg_val = pwdata[RB_W-1:0];
        if (cfg_val == '0)
        begin
            cfg_val = RB_W'(1);
        end
        else if ({8'b0, cfg_val} > 25'(RB_CLAMP))
        begin
            cfg_val = RB_W'(RB_CLAMP);
        end
    end

    // commit ticket range check
    assign tk_ext  = CW'(req.ticket);
    assign tk_live = (tk_ext < CW'(MAX_TICKETS)) && (tk_ext >= CW'(head_reg))
                   && (tk_ext < CW'(tail_reg));

    assign walk_go = (head_reg < tail_reg) && done_reg[head_reg[IW-1:0]];

    // span placement shared by reserve and commit walk
    assign walk_size = (state_reg == S_CM_MOD) ? ram_rdata : size_reg;
    assign fits = ({1'b0, mod_rem} + {1'b0, walk_size}) <= {1'b0, rb_reg};
    assign step = fits ? {1'b0, walk_size}
                       : ({1'b0, rb_reg} - {1'b0, mod_rem} + {1'b0, walk_size});

    assign rd_diff = alloc_reg - rp_reg;
    assign limit   = (rb_reg >= gap_reg) ? (rb_reg - gap_reg) : '0;

    // modulo unit operand select
    always_comb
    begin
        mod_start = 1'b0;
        mod_arg   = alloc_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && req.cmd == CMD_RESERVE && req.size != '0
                    && req.size <= rb_reg && tail_reg != TW'(MAX_TICKETS))
                begin
                    mod_start = 1'b1;
                    mod_arg   = alloc_reg;
                end
                else if (accept && req.cmd == CMD_READ
                         && (req.read_pos - safe_reg) >= 32'h8000_0000)
                begin
                    mod_start = 1'b1;
                    mod_arg   = req.read_pos;
                end
            end
            S_CM_WALK:
            begin
                mod_start = walk_go;
                mod_arg   = safe_reg;
            end
            S_RD_CHK:
            begin
                mod_start = !(rd_diff > POS_W'(rb_reg));
                mod_arg   = safe_reg;
            end
            default:
            begin
                mod_start = 1'b0;
                mod_arg   = alloc_reg;
            end
        endcase
    end

    assign ram_we = (state_reg == S_RES_MOD) && mod_done;
    assign ram_re = (state_reg == S_CM_WALK) && walk_go;

    rrct_ram #(
        .WIDTH (SIZE_W),
        .DEPTH (MAX_TICKETS)
    ) u_sizes (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tail_reg[IW-1:0]),
        .wdata (size_reg),
        .re    (ram_re),
        .raddr (head_reg[IW-1:0]),
        .rdata (ram_rdata)
    );

    rrct_mod u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (mod_arg),
        .divisor  (rb_reg),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    // sequencer and tracker state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rb_reg        <= RB_W'(RB_RESET);
            alloc_reg     <= '0;
            safe_reg      <= '0;
            gap_reg       <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_TICKETS; i++)
            begin
                done_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_wr)
            begin
                rb_reg <= cfg_val;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        size_reg <= req.size;
                        rp_reg   <= req.read_pos;
                        st_reg   <= ST_OK;
                        off_reg  <= '0;
                        len_reg  <= '0;
                        gt_reg   <= '0;
                        nrp_reg  <= '0;
                        case (req.cmd)
                            CMD_RESERVE:
                            begin
                                if (req.size == '0 || req.size > rb_reg)
                                begin
                                    st_reg        <= ST_BADSIZE;
                                    out_valid_reg <= 1'b1;
                                end
                                else if (tail_reg == TW'(MAX_TICKETS))
                                begin
                                    st_reg        <= ST_FULL;
                                    out_valid_reg <= 1'b1;
                                end
                                else
                                begin
                                    state_reg <= S_RES_MOD;
                                end
                            end
                            CMD_COMMIT:
                            begin
                                if (tk_live)
                                begin
                                    done_reg[IW'(req.ticket)] <= 1'b1;
                                end
                                state_reg <= S_CM_WALK;
                            end
                            CMD_READ:
                            begin
                                if ((req.read_pos - safe_reg) < 32'h8000_0000)
                                begin
                                    st_reg        <= ST_EMPTY;
                                    nrp_reg       <= req.read_pos;
                                    out_valid_reg <= 1'b1;
                                end
                                else
                                begin
                                    state_reg <= S_RD_MOD;
                                end
                            end
                            default:
                            begin
                                out_valid_reg <= 1'b1;
                            end
                        endcase
                    end
                end
                S_RES_MOD:
                begin
                    if (mod_done)
                    begin
                        alloc_reg <= alloc_reg + POS_W'(step);
                        if (!fits)
                        begin
                            gap_reg <= rb_reg - mod_rem;
                            off_reg <= '0;
                        end
                        else
                        begin
                            off_reg <= OFF_W'(mod_rem);
                        end
                        done_reg[tail_reg[IW-1:0]] <= 1'b0;
                        gt_reg        <= TK_W'(tail_reg);
                        tail_reg      <= tail_reg + 1'b1;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                S_CM_WALK:
                begin
                    if (walk_go)
                    begin
                        state_reg <= S_CM_MOD;
                    end
                    else
                    begin
                        if (head_reg == tail_reg)
                        begin
                            head_reg <= '0;
                            tail_reg <= '0;
                        end
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                S_CM_MOD:
                begin
                    if (mod_done)
                    begin
                        safe_reg  <= safe_reg + POS_W'(step);
                        head_reg  <= head_reg + 1'b1;
                        state_reg <= S_CM_WALK;
                    end
                end
                S_RD_MOD:
                begin
                    if (mod_done)
                    begin
                        ri_reg    <= mod_rem;
                        state_reg <= S_RD_ADJ;
                    end
                end
                S_RD_ADJ:
                begin
                    // reader at the start of the padding skips to the next lap
                    if ((rb_reg - ri_reg) == gap_reg)
                    begin
                        rp_reg <= rp_reg + POS_W'(gap_reg);
                        ri_reg <= '0;
                    end
                    state_reg <= S_RD_CHK;
                end
                S_RD_CHK:
                begin
                    if (rd_diff > POS_W'(rb_reg))
                    begin
                        st_reg        <= ST_OVERRUN;
                        nrp_reg       <= rp_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_RD_WMOD;
                    end
                end
                S_RD_WMOD:
                begin
                    if (mod_done)
                    begin
                        if (ri_reg < mod_rem)
                        begin
                            off_reg <= OFF_W'(ri_reg);
                            len_reg <= mod_rem - ri_reg;
                            nrp_reg <= rp_reg + POS_W'(mod_rem - ri_reg);
                        end
                        else if (ri_reg >= limit)
                        begin
                            st_reg  <= ST_EMPTY;
                            nrp_reg <= rp_reg;
                        end
                        else
                        begin
                            off_reg <= OFF_W'(ri_reg);
                            len_reg <= limit - ri_reg;
                            nrp_reg <= rp_reg + POS_W'(limit - ri_reg);
                        end
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // result channel
    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = st_reg;
    assign rsp.offset         = off_reg;
    assign rsp.length         = len_reg;
    assign rsp.granted_ticket = gt_reg;
    assign rsp.new_read_pos   = nrp_reg;

    `RRCT_ASSERT(a_queue_order, (head_reg <= tail_reg) && (tail_reg <= TW'(MAX_TICKETS)));
    `RRCT_ASSERT(a_result_ends_item, $rose(out_valid_reg) |-> (state_reg == S_IDLE));
    `RRCT_ASSERT(a_mod_done_waiting,
        mod_done |-> (state_reg == S_RES_MOD || state_reg == S_CM_MOD
                      || state_reg == S_RD_MOD || state_reg == S_RD_WMOD));
    `RRCT_ASSERT(a_head_moves_on_done,
        (head_reg != $past(head_reg) && head_reg != '0) |-> $past(mod_done));
endmodule

// ----- bench/ring_reserve_commit_tracker_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ring_reserve_commit_tracker_core_tb
// self-checking bench for the ring reserve/commit tracker: a behavioral
// ring tracker predicts every result, random request gaps and result stalls
// exercise the handshakes, and the ring size is changed between phases
// ----------------------------------------------------------------------------
module ring_reserve_commit_tracker_core_tb;
    import rrct_pkg::*;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [OFF_W-1:0]  offset;
        logic [SIZE_W-1:0] length;
        logic [TK_W-1:0]   granted;
        logic [POS_W-1:0]  new_pos;
    } ring_result_t;

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite, pready;
    logic [2:0]  paddr;
    logic [31:0] pwdata, prdata;

    rrct_req_if req ();
    rrct_rsp_if rsp ();

    ring_reserve_commit_tracker_core i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req.sink),
        .rsp     (rsp.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // tracker state mirrored by the bench
    logic [31:0] ring_len;
    logic [31:0] alloc_at;
    logic [31:0] safe_at;
    logic [31:0] pad_len;
    logic [31:0] tk_len [32];
    logic        tk_done [32];
    int unsigned tk_head, tk_tail;

    ring_result_t pending_q [$];
    ring_result_t last_res;
    int errors = 0;
    int n_checked = 0;
    int n_reserve = 0, n_commit = 0, n_read = 0, n_wrap = 0;
    logic [31:0] reader_at;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [31:0] ring_advance(logic [31:0] pos, logic [31:0] n);
        logic [31:0] off;
        off = pos % ring_len;
        if (64'(off) + 64'(n) <= 64'(ring_len))
            return pos + n;
        return pos - off + ring_len + n;
    endfunction

    // work out the result of one accepted request and update the mirror
    function automatic ring_result_t ring_apply(cmd_t cmd, logic [16:0] size,
                                                logic [4:0] tk, logic [31:0] rp);
        ring_result_t r;
        logic [31:0] off, ri, wi, len, lim;
        r = '0;
        case (cmd)
            CMD_RESERVE:
            begin
                if (size == 0 || 32'(size) > ring_len)
                    r.status = ST_BADSIZE;
                else if (tk_tail >= 32)
                    r.status = ST_FULL;
                else
                begin
                    off = alloc_at % ring_len;
                    if (off + 32'(size) <= ring_len)
                        alloc_at = alloc_at + 32'(size);
                    else
                    begin
                        pad_len = ring_len - off;
                        alloc_at = alloc_at - off + ring_len + 32'(size);
                        off = 0;
                        n_wrap++;
                    end
                    tk_len[tk_tail] = 32'(size);
                    tk_done[tk_tail] = 1'b0;
                    r.status = ST_OK;
                    r.offset = off[15:0];
                    r.granted = tk_tail[4:0];
                    tk_tail++;
                end
            end
            CMD_COMMIT:
            begin
                if (tk >= tk_head && tk < tk_tail)
                    tk_done[tk] = 1'b1;
                while (tk_head < tk_tail && tk_done[tk_head])
                begin
                    safe_at = ring_advance(safe_at, tk_len[tk_head]);
                    tk_head++;
                end
                if (tk_head == tk_tail)
                begin
                    tk_head = 0;
                    tk_tail = 0;
                end
            end
            CMD_READ:
            begin
                r.new_pos = rp;
                if (((rp - safe_at) & 32'h8000_0000) == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    ri = rp % ring_len;
                    if (ring_len - ri == pad_len)
                    begin
                        rp = rp + pad_len;
                        ri = 0;
                    end
                    r.new_pos = rp;
                    wi = safe_at % ring_len;
                    lim = (ring_len >= pad_len) ? ring_len - pad_len : 0;
                    if (alloc_at - rp > ring_len)
                        r.status = ST_OVERRUN;
                    else if (ri >= wi && ri >= lim)
                        r.status = ST_EMPTY;
                    else
                    begin
                        len = (ri < wi) ? wi - ri : lim - ri;
                        r.status = ST_OK;
                        r.offset = ri[15:0];
                        r.length = len[16:0];
                        r.new_pos = rp + len;
                    end
                end
            end
            default: r = '0;
        endcase
        return r;
    endfunction

    // send one request; valid stays high into the next call when no gap follows
    task automatic send_request(cmd_t cmd, logic [16:0] size, logic [4:0] tk,
                                logic [31:0] rp);
        int gap;
        req.valid    <= 1'b1;
        req.cmd      <= cmd;
        req.size     <= size;
        req.ticket   <= tk;
        req.read_pos <= rp;
        do
            @(posedge clk);
        while (!req.ready);
        last_res = ring_apply(cmd, size, tk, rp);
        pending_q.push_back(last_res);
        case (cmd)
            CMD_RESERVE: n_reserve++;
            CMD_COMMIT:  n_commit++;
            CMD_READ:    n_read++;
            default:     ;
        endcase
        gap = ($urandom_range(0, 3) == 0) ? 0 :
              ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
        if ($urandom_range(0, 2) == 0)
            gap = 0;
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // wait until every result is in, then leave the block idle a little
    task automatic wait_idle();
        req.valid <= 1'b0;
        @(posedge clk);
        while (pending_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_ring_bytes(logic [31:0] value);
        logic [31:0] v;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_RING_BYTES;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        v = value & 32'h1FFFF;
        if (v == 0)
            v = 1;
        if (v > 65536)
            v = 65536;
        ring_len = v;
        @(posedge clk);
    endtask

    // result stall pattern: mostly short runs, a few long stalls
    int unsigned stall_left = 0;
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            if ($urandom_range(0, 2) != 0)
            begin
                rsp.ready  <= 1'b1;
                stall_left <= $urandom_range(1, 20);
            end
            else
            begin
                rsp.ready  <= 1'b0;
                stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
                                                          : $urandom_range(1, 3);
            end
        end
        else
            stall_left <= stall_left - 1;
    end

    // compare each taken result with the oldest prediction
    always @(posedge clk)
    begin
        ring_result_t e;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (pending_q.size() == 0)
            begin
                $error("result with no request pending");
                errors++;
            end
            else
            begin
                e = pending_q.pop_front();
                n_checked++;
                if (rsp.status !== e.status)
                begin
                    $error("status exp %0d got %0d", e.status, rsp.status);
                    errors++;
                end
                if (rsp.offset !== e.offset)
                begin
                    $error("offset exp %0d got %0d", e.offset, rsp.offset);
                    errors++;
                end
                if (rsp.length !== e.length)
                begin
                    $error("length exp %0d got %0d", e.length, rsp.length);
                    errors++;
                end
                if (rsp.granted_ticket !== e.granted)
                begin
                    $error("granted_ticket exp %0d got %0d", e.granted, rsp.granted_ticket);
                    errors++;
                end
                if (rsp.new_read_pos !== e.new_pos)
                begin
                    $error("new_read_pos exp %0h got %0h", e.new_pos, rsp.new_read_pos);
                    errors++;
                end
            end
        end
    end

    // size checks, exact fit, full ticket queue, stray commits, unknown command
    task automatic test_directed_basic();
        send_request(CMD_RESERVE, 17'd0, 5'd0, 32'd0);
        send_request(CMD_RESERVE, 17'h1FFFF, 5'd0, 32'd0);
        send_request(CMD_READ, 17'd0, 5'd0, 32'd0);
        send_request(CMD_RESERVE, 17'd65536, 5'd0, 32'd0);
        send_request(CMD_COMMIT, 17'd0, 5'd31, 32'd0);
        send_request(CMD_COMMIT, 17'd0, 5'd0, 32'd0);
        send_request(CMD_READ, 17'd0, 5'd0, 32'd0);
        send_request(CMD_NONE, 17'h1FFFF, 5'h1F, 32'hFFFF_FFFF);
        for (int i = 0; i < 33; i++)
            send_request(CMD_RESERVE, 17'd1, 5'd0, 32'd0);
        for (int i = 31; i >= 0; i--)
            send_request(CMD_COMMIT, 17'd0, 5'(i), 32'd0);
        send_request(CMD_READ, 17'd0, 5'd0, 32'h8000_0000);
        send_request(CMD_READ, 17'd0, 5'd0, 32'd65536);
        wait_idle();
    endtask

    // padding at the ring end: skip at its start, nothing readable inside it
    task automatic test_directed_padding();
        write_ring_bytes(32'd100);
        send_request(CMD_RESERVE, 17'd60, 5'd0, 32'd0);
        send_request(CMD_RESERVE, 17'd50, 5'd0, 32'd0);
        send_request(CMD_READ, 17'd0, 5'd0, safe_at - 32'd10);
        send_request(CMD_COMMIT, 17'd0, 5'd1, 32'd0);
        send_request(CMD_COMMIT, 17'd0, 5'd0, 32'd0);
        reader_at = safe_at - 32'd110;
        send_request(CMD_READ, 17'd0, 5'd0, reader_at);
        send_request(CMD_READ, 17'd0, 5'd0, last_res.new_pos);
        send_request(CMD_READ, 17'd0, 5'd0, last_res.new_pos + 32'd5);
        send_request(CMD_READ, 17'd0, 5'd0, safe_at - 32'd1000);
        wait_idle();
    endtask

    // random well-formed traffic with some noise, for one ring size
    task automatic test_random_phase(logic [31:0] rb_value, int count);
        int pick;
        logic [16:0] sz;
        logic [4:0]  tk;
        logic [31:0] rp;
        write_ring_bytes(rb_value);
        reader_at = safe_at;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
            begin
                case ($urandom_range(0, 19))
                    0: sz = 17'd0;
                    1: sz = 17'(ring_len);
                    2: sz = 17'($urandom_range(ring_len, 17'h1FFFF));
                    default: sz = 17'($urandom_range(1, ring_len / 3 + 1));
                endcase
                send_request(CMD_RESERVE, sz, 5'($urandom), 32'($urandom));
            end
            else if (pick < 70)
            begin
                if (tk_tail > tk_head && $urandom_range(0, 9) != 0)
                    tk = 5'($urandom_range(tk_head, tk_tail - 1));
                else
                    tk = 5'($urandom);
                send_request(CMD_COMMIT, 17'($urandom), tk, 32'($urandom));
            end
            else if (pick < 95)
            begin
                case ($urandom_range(0, 9))
                    0: rp = $urandom;
                    1: rp = safe_at - ring_len - 32'($urandom_range(1, 50));
                    2: rp = safe_at - 32'($urandom_range(1, 3));
                    default: rp = reader_at;
                endcase
                send_request(CMD_READ, 17'($urandom), 5'($urandom), rp);
                if (last_res.status == ST_OK)
                    reader_at = last_res.new_pos;
                else if (last_res.status == ST_OVERRUN)
                    reader_at = safe_at - 32'($urandom_range(1, ring_len));
            end
            else
                send_request(CMD_NONE, 17'($urandom), 5'($urandom), $urandom);
        end
        wait_idle();
    endtask

    initial
    begin
        rst_n       = 1'b0;
        req.valid   = 1'b0;
        req.cmd     = CMD_NONE;
        req.size    = '0;
        req.ticket  = '0;
        req.read_pos = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        ring_len    = 32'd65536;
        alloc_at    = '0;
        safe_at     = '0;
        pad_len     = '0;
        tk_head     = 0;
        tk_tail     = 0;
        reader_at   = '0;
        for (int i = 0; i < 32; i++)
        begin
            tk_len[i]  = '0;
            tk_done[i] = 1'b0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        test_directed_basic();
        test_directed_padding();
        test_random_phase(32'd65536, 200);
        test_random_phase(32'd100, 200);
        test_random_phase(32'd0, 100);
        test_random_phase(32'd16, 200);
        test_random_phase(32'h1FFFF, 200);
        test_random_phase(32'd37, 200);
        test_random_phase(32'd4096, 200);

        $display("checked %0d results: %0d reserves (%0d wrapped), %0d commits, %0d reads",
                 n_checked, n_reserve, n_wrap, n_commit, n_read);
        $display("ring sizes 1 to 65536 including clamped register writes");
        if (errors == 0)
            $display("ring_reserve_commit_tracker_core: match");
        else
            $display("ring_reserve_commit_tracker_core: mismatch");
        $finish;
    end

    // hard stop well beyond the slowest legal run
    initial
    begin
        #40ms;
        $display("ring_reserve_commit_tracker_core: mismatch");
        $finish;
    end

endmodule
